>>> rtl/text_glyph_frame_renderer_macros.svh
// Assertion macros shared by the text glyph frame renderer RTL.
`ifndef TEXT_GLYPH_FRAME_RENDERER_MACROS_SVH
`define TEXT_GLYPH_FRAME_RENDERER_MACROS_SVH
`ifndef SYNTHESIS
`define TGFR_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("text glyph frame renderer assertion failed");
`define TGFR_NEVER(lbl, clk, rst_n, cond) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error("text glyph frame renderer forbidden condition seen");
`else
`define TGFR_ASSERT(lbl, clk, rst_n, prop)
`define TGFR_NEVER(lbl, clk, rst_n, cond)
`endif
`endif

>>> rtl/tgfr_pkg.sv
// Constants, types and font table of the text glyph frame renderer.
package tgfr_pkg;

	localparam int DISPLAY_WIDTH = 128;
	localparam int DISPLAY_HEIGHT = 64;
	localparam int PAGE_COUNT = (DISPLAY_HEIGHT + 7) / 8;
	localparam int FRAME_BYTES = DISPLAY_WIDTH * PAGE_COUNT;
	localparam int ADDR_W = $clog2(FRAME_BYTES);
	localparam int CELL_WIDTH = 6;
	localparam int GLYPH_COLS = 5;
	localparam int GLYPH_ROWS = 7;
	localparam int LEN_W = 5;
	localparam int TOP_W = 6;
	localparam int PG_W = TOP_W - 3 + 1;
	localparam int LINE_W = $clog2((1 << LEN_W) * CELL_WIDTH);
	localparam int COL_W = $clog2(DISPLAY_WIDTH + (1 << LEN_W) * CELL_WIDTH + GLYPH_COLS);
	localparam int DRAW_STEPS = GLYPH_COLS * 2;
	localparam int STEP_W = $clog2(DRAW_STEPS);
	localparam int GLYPH_W = GLYPH_COLS * 8;

	typedef enum logic [1:0] {
		OP_CLEAR = 2'd0,
		OP_DRAW  = 2'd1,
		OP_READ  = 2'd2,
		OP_NONE  = 2'd3
	} op_t;

	typedef enum logic [4:0] {
		S_CLEAR = 5'b00001,
		S_IDLE  = 5'b00010,
		S_DRAW  = 5'b00100,
		S_READ  = 5'b01000,
		S_LOAD  = 5'b10000
	} state_t;

	typedef logic [GLYPH_W-1:0] glyph_t;

	localparam glyph_t FONT_DIGIT [10] = '{
		40'h3e_45_49_51_3e, 40'h00_40_7f_42_00, 40'h46_49_51_61_42,
		40'h31_4b_45_41_21, 40'h10_7f_12_14_18, 40'h39_45_45_45_27,
		40'h30_49_49_4a_3c, 40'h03_05_09_71_01, 40'h36_49_49_49_36,
		40'h1e_29_49_49_06
	};

	localparam glyph_t FONT_ALPHA [26] = '{
		40'h7e_11_11_11_7e, 40'h36_49_49_49_7f, 40'h22_41_41_41_3e,
		40'h1c_22_41_41_7f, 40'h41_49_49_49_7f, 40'h01_09_09_09_7f,
		40'h7a_49_49_41_3e, 40'h7f_08_08_08_7f, 40'h00_41_7f_41_00,
		40'h01_3f_41_40_20, 40'h41_22_14_08_7f, 40'h40_40_40_40_7f,
		40'h7f_02_0c_02_7f, 40'h7f_10_08_04_7f, 40'h3e_41_41_41_3e,
		40'h06_09_09_09_7f, 40'h5e_21_51_41_3e, 40'h46_29_19_09_7f,
		40'h31_49_49_49_46, 40'h01_01_7f_01_01, 40'h3f_40_40_40_3f,
		40'h1f_20_40_20_1f, 40'h3f_40_38_40_3f, 40'h63_14_08_14_63,
		40'h07_08_70_08_07, 40'h43_45_49_51_61
	};

	localparam glyph_t FONT_SPACE  = 40'h00_00_00_00_00;
	localparam glyph_t FONT_COLON  = 40'h00_00_36_36_00;
	localparam glyph_t FONT_PERIOD = 40'h00_00_60_60_00;
	localparam glyph_t FONT_PLUS   = 40'h08_08_3e_08_08;
	localparam glyph_t FONT_DASH   = 40'h08_08_08_08_08;
	localparam glyph_t FONT_QUERY  = 40'h06_09_51_01_02;

	// Column c of the glyph sits in bits [8c+7:8c].
	function automatic glyph_t font_glyph(input logic [7:0] code);
		logic [7:0] up;
		glyph_t g;
		up = code;
		if (code >= 8'h61 && code <= 8'h7a) begin
			up = code - 8'h20;
		end
		if (up >= 8'h30 && up <= 8'h39) begin
			g = FONT_DIGIT[4'(up - 8'h30)];
		end else if (up >= 8'h41 && up <= 8'h5a) begin
			g = FONT_ALPHA[5'(up - 8'h41)];
		end else begin
			unique case (up)
				8'h20:   g = FONT_SPACE;
				8'h3a:   g = FONT_COLON;
				8'h2e:   g = FONT_PERIOD;
				8'h2b:   g = FONT_PLUS;
				8'h2d:   g = FONT_DASH;
				default: g = FONT_QUERY;
			endcase
		end
		return g;
	endfunction

	// Bits of a page byte whose pixel rows lie on the display.
	function automatic logic [7:0] page_row_mask(input logic [PG_W-1:0] page);
		logic [7:0] m;
		for (int n = 0; n < 8; n++) begin
			m[n] = (int'(page) * 8 + n) < DISPLAY_HEIGHT;
		end
		return m;
	endfunction

endpackage

>>> rtl/tgfr_frame_ram.sv
// Frame store: one write port and one registered read port.
module tgfr_frame_ram (
	input  logic                      clk,
	input  logic                      we,
	input  logic [tgfr_pkg::ADDR_W-1:0] waddr,
	input  logic [7:0]                wdata,
	input  logic                      re,
	input  logic [tgfr_pkg::ADDR_W-1:0] raddr,
	output logic [7:0]                rdata
);

	logic [7:0] mem [tgfr_pkg::FRAME_BYTES];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

>>> rtl/text_glyph_frame_renderer.sv
// Top level of the text glyph frame renderer: op sequencer around the frame store.
// After reset a clearing pass writes all 1024 frame bytes, one per cycle, with in_ready low.
// A clear op writes every frame byte again, one frame byte per cycle through the RAM write port.
// A draw does read-modify-write over five columns on two pages.
// A read goes through S_READ, then S_LOAD until the output is free; other ops return to idle.
// Reset is asynchronous and active low; it clears all control state.
`include "text_glyph_frame_renderer_macros.svh"

module text_glyph_frame_renderer (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  op,
	input  logic [4:0]  text_length,
	input  logic [4:0]  char_index,
	input  logic [7:0]  char_code,
	input  logic [5:0]  top_row,
	input  logic [9:0]  read_address,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  read_data
);

	tgfr_pkg::state_t state_q;
	logic [tgfr_pkg::ADDR_W-1:0] clr_q;
	logic [tgfr_pkg::STEP_W-1:0] step_q;
	logic [tgfr_pkg::COL_W-1:0] left_q;
	logic [tgfr_pkg::TOP_W-1:0] top_q;
	tgfr_pkg::glyph_t glyph_q;
	logic [tgfr_pkg::ADDR_W-1:0] raddr_q;
	logic oob_q;
	logic out_valid_q;
	logic [7:0] out_data_q;

	logic wr_en_s1;
	logic [tgfr_pkg::ADDR_W-1:0] wr_addr_s1;
	logic [7:0] bits_s1;

	logic accept;
	logic [tgfr_pkg::LINE_W-1:0] line_w;
	logic [tgfr_pkg::COL_W-1:0] start_col;
	logic [tgfr_pkg::COL_W-1:0] left_col;
	logic draw_ok;

	logic [2:0] col_sel;
	logic [tgfr_pkg::PG_W-1:0] page;
	logic page_ok;
	logic [tgfr_pkg::COL_W-1:0] col;
	logic [tgfr_pkg::ADDR_W-1:0] draw_addr;
	logic [15:0] shifted;
	logic [7:0] draw_bits;

	logic ram_we;
	logic [tgfr_pkg::ADDR_W-1:0] ram_waddr;
	logic [7:0] ram_wdata;
	logic ram_re;
	logic [tgfr_pkg::ADDR_W-1:0] ram_raddr;
	logic [7:0] ram_rdata;
	logic load_out;

	assign in_ready = (state_q == tgfr_pkg::S_IDLE);
	assign accept = in_valid && in_ready;
	assign out_valid = out_valid_q;
	assign read_data = out_data_q;

	always_comb begin
		line_w = tgfr_pkg::LINE_W'(int'(text_length) * tgfr_pkg::CELL_WIDTH);
		if (int'(line_w) < tgfr_pkg::DISPLAY_WIDTH) begin
			start_col = tgfr_pkg::COL_W'((tgfr_pkg::DISPLAY_WIDTH - int'(line_w)) / 2);
		end else begin
			start_col = '0;
		end
		left_col = start_col + tgfr_pkg::COL_W'(int'(char_index) * tgfr_pkg::CELL_WIDTH);
		draw_ok = (char_index < text_length)
			&& (int'(left_col) + tgfr_pkg::GLYPH_COLS <= tgfr_pkg::DISPLAY_WIDTH);
	end

	always_comb begin
		col_sel = step_q[tgfr_pkg::STEP_W-1:1];
		page = tgfr_pkg::PG_W'(top_q[tgfr_pkg::TOP_W-1:3]) + tgfr_pkg::PG_W'(step_q[0]);
		page_ok = int'(page) < tgfr_pkg::PAGE_COUNT;
		col = left_q + tgfr_pkg::COL_W'(col_sel);
		draw_addr = tgfr_pkg::ADDR_W'(int'(page) * tgfr_pkg::DISPLAY_WIDTH + int'(col));
		shifted = {8'h00, glyph_q[col_sel*8 +: 8]} << top_q[2:0];
		draw_bits = (step_q[0] ? shifted[15:8] : shifted[7:0]) & tgfr_pkg::page_row_mask(page);
	end

	assign load_out = (state_q == tgfr_pkg::S_LOAD) && (!out_valid_q || out_ready);

	always_comb begin
		ram_re = 1'b0;
		ram_raddr = raddr_q;
		if (state_q == tgfr_pkg::S_DRAW) begin
			ram_re = page_ok;
			ram_raddr = draw_addr;
		end else if (state_q == tgfr_pkg::S_READ) begin
			ram_re = 1'b1;
		end
	end

	always_comb begin
		if (state_q == tgfr_pkg::S_CLEAR) begin
			ram_we = 1'b1;
			ram_waddr = clr_q;
			ram_wdata = 8'h00;
		end else begin
			ram_we = wr_en_s1;
			ram_waddr = wr_addr_s1;
			ram_wdata = ram_rdata | bits_s1;
		end
	end

	tgfr_frame_ram u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tgfr_pkg::S_CLEAR;
			clr_q <= '0;
			step_q <= '0;
			out_valid_q <= 1'b0;
			wr_en_s1 <= 1'b0;
		end else begin
			wr_en_s1 <= (state_q == tgfr_pkg::S_DRAW) && page_ok;
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				tgfr_pkg::S_CLEAR: begin
					if (clr_q == tgfr_pkg::ADDR_W'(tgfr_pkg::FRAME_BYTES - 1)) begin
						state_q <= tgfr_pkg::S_IDLE;
					end
					clr_q <= clr_q + 1'b1;
				end
				tgfr_pkg::S_IDLE: begin
					if (accept) begin
						step_q <= '0;
						clr_q <= '0;
						priority if (op == tgfr_pkg::OP_CLEAR) begin
							state_q <= tgfr_pkg::S_CLEAR;
						end else if (op == tgfr_pkg::OP_DRAW && draw_ok) begin
							state_q <= tgfr_pkg::S_DRAW;
						end else if (op == tgfr_pkg::OP_READ) begin
							state_q <= tgfr_pkg::S_READ;
						end else begin
							state_q <= tgfr_pkg::S_IDLE;
						end
					end
				end
				tgfr_pkg::S_DRAW: begin
					if (step_q == tgfr_pkg::STEP_W'(tgfr_pkg::DRAW_STEPS - 1)) begin
						state_q <= tgfr_pkg::S_IDLE;
					end
					step_q <= step_q + 1'b1;
				end
				tgfr_pkg::S_READ: begin
					state_q <= tgfr_pkg::S_LOAD;
				end
				tgfr_pkg::S_LOAD: begin
					if (load_out) begin
						state_q <= tgfr_pkg::S_IDLE;
					end
				end
				default: begin
					state_q <= tgfr_pkg::S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		wr_addr_s1 <= draw_addr;
		bits_s1 <= draw_bits;
		if (accept) begin
			left_q <= left_col;
			top_q <= top_row;
			glyph_q <= tgfr_pkg::font_glyph(char_code);
			raddr_q <= tgfr_pkg::ADDR_W'(read_address);
			oob_q <= int'(read_address) >= tgfr_pkg::FRAME_BYTES;
		end
		if (load_out) begin
			out_data_q <= oob_q ? 8'h00 : ram_rdata;
		end
	end

	`TGFR_NEVER(a_no_rw_overlap, clk, arst_n, wr_en_s1 && ram_re && (wr_addr_s1 == ram_raddr))
	`TGFR_ASSERT(a_out_from_load, clk, arst_n, $rose(out_valid_q) |-> $past(state_q == tgfr_pkg::S_LOAD))
	`TGFR_ASSERT(a_step_bound, clk, arst_n, (state_q == tgfr_pkg::S_DRAW) |-> (int'(step_q) < tgfr_pkg::DRAW_STEPS))
	`TGFR_ASSERT(a_clear_follows, clk, arst_n, (accept && op == tgfr_pkg::OP_CLEAR) |=> (state_q == tgfr_pkg::S_CLEAR && clr_q == '0))
	`TGFR_NEVER(a_no_write_in_read, clk, arst_n, ram_we && (state_q == tgfr_pkg::S_READ))

endmodule
